### rtl/core/bbt_pkg.sv
// bbt_pkg: command codes and the structs passed along the cell chain of the bag table.
// Used by bbt_cell, bounded_bag_table_top and the testbench. No dependencies.
package bbt_pkg;

    localparam int VALUE_W = 32;
    localparam int CMD_W   = 3;
    localparam int MCNT_W  = 4;
    localparam int TOTAL_W = 35;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREQ     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SUM      = 3'd5;

    // Probe item that walks the chain, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic               hit;
        logic [MCNT_W-1:0]  hit_cnt;
        logic [TOTAL_W-1:0] total;
    } probe_t;

    // Update controls broadcast to all cells at the end of a sweep.
    typedef struct packed {
        logic               add_en;
        logic               commit;
        logic [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

### rtl/core/bbt_cell.sv
// bbt_cell: a bag slot; holds an entry, set on an add, scans the passing
// probe and shifts its neighbor's entry in on a remove. Depends on bbt_pkg.
module bbt_cell
    import bbt_pkg::*;
#(
    parameter int CNT_W = 4,
    parameter int IDX   = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   count,
    input  cell_ctl_t          ctl,
    input  probe_t             probe_in,
    output probe_t             probe_out,
    input  logic [VALUE_W-1:0] next_entry,
    output logic [VALUE_W-1:0] entry
);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               shift_reg;
    logic               shift_next;
    probe_t             probe_reg;
    probe_t             probe_next;
    logic               active;
    logic               match;
    logic [TOTAL_W-1:0] entry_ext;

    assign active    = (CNT_W'(IDX) < count);
    assign match     = active && (entry_reg == probe_in.value);
    assign entry_ext = {{(TOTAL_W-VALUE_W){entry_reg[VALUE_W-1]}}, entry_reg};

    always_comb
    begin
        probe_next         = probe_in;
        probe_next.hit     = probe_in.hit | match;
        probe_next.hit_cnt = probe_in.hit_cnt + MCNT_W'(match);
        probe_next.total   = probe_in.total + (active ? entry_ext : '0);
    end

    always_comb
    begin
        shift_next = shift_reg;
        if (probe_in.valid)
        begin
            shift_next = (probe_in.cmd == CMD_REMOVE) && active && (probe_in.hit || match);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.add_en && (count == CNT_W'(IDX)))
        begin
            entry_next = ctl.value;
        end
        else if (ctl.commit && shift_reg)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            shift_reg <= 1'b0;
        end
        else
        begin
            probe_reg <= probe_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign probe_out = probe_reg;
    assign entry     = entry_reg;

endmodule

### rtl/core/bounded_bag_table_top.sv
// bounded_bag_table_top: fixed-capacity bag of signed 32-bit values built as a chain of cells.
// Depends on bbt_pkg and bbt_cell.
//
// A command is taken when start is high and busy is low. A probe then walks the row of
// CAPACITY cells, one cell per cycle, and the last cell's output is registered into the
// result ports; busy stays high until the probe leaves the last cell, and a new command
// may start in the cycle its predecessor's result is shown.
// done is high for exactly one cycle with each result; the ports hold it until the next result.
module bounded_bag_table_top
    import bbt_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CMD_W-1:0]          cmd,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      done,
    output logic                      ok,
    output logic [MCNT_W-1:0]         match_count,
    output logic [3:0]                size,
    output logic                      empty_res,
    output logic signed [TOTAL_W-1:0] total
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    logic               ok_reg;
    logic               ok_next;
    logic [MCNT_W-1:0]  mcnt_reg;
    logic [MCNT_W-1:0]  mcnt_next;
    logic [3:0]         size_reg;
    logic               empty_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               accept;
    logic               finish;
    logic               not_full;
    probe_t             launch;
    probe_t             last;
    cell_ctl_t          ctl;

    probe_t             probes  [0:CAPACITY];
    logic [VALUE_W-1:0] entries [0:CAPACITY];

    assign accept   = start && (state_reg == ST_IDLE);
    assign last     = probes[CAPACITY];
    assign finish   = last.valid;
    assign not_full = (count_reg < CNT_W'(CAPACITY));

    always_comb
    begin
        launch         = '0;
        launch.valid   = accept;
        launch.cmd     = cmd;
        launch.value   = value;
    end

    assign probes[0]         = launch;
    assign entries[CAPACITY] = '0;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            bbt_cell #(
                .CNT_W (CNT_W),
                .IDX   (i)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .count      (count_reg),
                .ctl        (ctl),
                .probe_in   (probes[i]),
                .probe_out  (probes[i+1]),
                .next_entry (entries[i+1]),
                .entry      (entries[i])
            );
        end
    endgenerate

    always_comb
    begin
        ctl.add_en = finish && (last.cmd == CMD_ADD) && not_full;
        ctl.commit = finish && (last.cmd == CMD_REMOVE) && last.hit;
        ctl.value  = last.value;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        ok_next    = 1'b0;
        mcnt_next  = '0;
        total_next = '0;
        case (last.cmd)
            CMD_ADD:
            begin
                ok_next = not_full;
                if (not_full)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                ok_next = last.hit;
                if (last.hit)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_CONTAINS:
            begin
                ok_next = last.hit;
            end
            CMD_FREQ:
            begin
                mcnt_next = last.hit_cnt;
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_SUM:
            begin
                total_next = last.total;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            ok_reg    <= ok_next;
            mcnt_reg  <= mcnt_next;
            size_reg  <= 4'(count_next);
            empty_reg <= (count_next == '0);
            total_reg <= total_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign match_count = mcnt_reg;
    assign size        = size_reg;
    assign empty_res   = empty_reg;
    assign total       = total_reg;

endmodule

### verif/bounded_bag_table_top_tb.sv
`timescale 1ns / 100ps
// bounded_bag_table_top_tb: directed table plus random command sequences for the bag table,
// each result checked against an in-bench model of the bag or a typed row's own expectation.
// Depends on bbt_pkg and bounded_bag_table_top.
module bounded_bag_table_top_tb;
    import bbt_pkg::*;

    localparam int BAG_DEPTH = 8;
    localparam int RANDOM_ITEMS = 1525;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               ok;
        logic [MCNT_W-1:0]  match_count;
        logic [3:0]         size;
        logic               empty_res;
        logic [TOTAL_W-1:0] total;
    } bag_res_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic               typed;
        bag_res_t           res;
    } dir_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic                      done;
    logic                      ok;
    logic [MCNT_W-1:0]         match_count;
    logic [3:0]                size;
    logic                      empty_res;
    logic signed [TOTAL_W-1:0] total;

    logic [VALUE_W-1:0] bag_vals [BAG_DEPTH];
    int                 bag_count;
    bag_res_t           pending_results [$];
    dir_row_t           dir_rows [$];
    logic [VALUE_W-1:0] value_pool [4];
    int                 mismatches;
    int                 items_sent;

    bounded_bag_table_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .value       (value),
        .done        (done),
        .ok          (ok),
        .match_count (match_count),
        .size        (size),
        .empty_res   (empty_res),
        .total       (total)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic bag_res_t bag_apply(input logic [CMD_W-1:0] c,
                                           input logic [VALUE_W-1:0] v);
        bag_res_t r;
        int       hit_idx;
        r = '0;
        hit_idx = -1;
        for (int i = 0; i < bag_count; i++)
        begin
            if (bag_vals[i] == v)
            begin
                if (hit_idx < 0)
                    hit_idx = i;
                if (c == CMD_FREQ)
                    r.match_count = r.match_count + 1'b1;
            end
            if (c == CMD_SUM)
                r.total = r.total + {{(TOTAL_W-VALUE_W){bag_vals[i][VALUE_W-1]}}, bag_vals[i]};
        end
        case (c)
            CMD_ADD:
            begin
                if (bag_count < BAG_DEPTH)
                begin
                    bag_vals[bag_count] = v;
                    bag_count++;
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (hit_idx >= 0)
                begin
                    bag_count--;
                    bag_vals[hit_idx] = bag_vals[bag_count];
                    r.ok = 1'b1;
                end
            end
            CMD_CONTAINS: r.ok = (hit_idx >= 0);
            CMD_CLEAR: bag_count = 0;
            default: ;
        endcase
        r.size = bag_count[3:0];
        r.empty_res = (bag_count == 0);
        return r;
    endfunction

    task automatic dir_row(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v,
                           input logic typed, input logic e_ok, input logic [3:0] e_mc,
                           input logic [3:0] e_size, input logic e_empty,
                           input logic [TOTAL_W-1:0] e_total);
        dir_row_t row;
        row.cmd = c;
        row.value = v;
        row.typed = typed;
        row.res = '{ok: e_ok, match_count: e_mc, size: e_size, empty_res: e_empty,
                    total: e_total};
        dir_rows = {dir_rows, row};
    endtask

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v,
                             input int gap, input logic typed, input bag_res_t typed_res);
        bag_res_t r;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = bag_apply(c, v);
        if (typed)
            r = typed_res;
        pending_results = {pending_results, r};
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return VAL_NEG1;
            default: return '0;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, 3)];
    endfunction

    function automatic int pick_gap(input logic no_idle);
        return no_idle ? 0 : $urandom_range(0, 13);
    endfunction

    always @(posedge clk)
    begin
        bag_res_t got;
        bag_res_t want;
        if (rst_n && done)
        begin
            got = '{ok: ok, match_count: match_count, size: size, empty_res: empty_res,
                    total: total};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: ok=%b mc=%0d size=%0d empty=%b total=%h",
                             got.ok, got.match_count, got.size, got.empty_res, got.total);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("item mismatch: exp ok=%b mc=%0d size=%0d empty=%b total=%h %s",
                                 want.ok, want.match_count, want.size, want.empty_res,
                                 want.total, $sformatf("got ok=%b mc=%0d size=%0d empty=%b total=%h",
                                 got.ok, got.match_count, got.size, got.empty_res, got.total));
                end
            end
        end
    end

    initial
    begin
        logic             no_idle;
        logic [VALUE_W-1:0] v;
        int               kind;
        int               seq_len;
        int               r;
        bag_res_t         none;
        none = '0;
        mismatches = 0;
        items_sent = 0;
        bag_count = 0;
        for (int i = 0; i < BAG_DEPTH; i++)
            bag_vals[i] = '0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        value = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_row(CMD_SUM,       '0,        1, 0, 0, 0, 1, '0);
        dir_row(CMD_REMOVE,    32'd5,     1, 0, 0, 0, 1, '0);
        dir_row(CMD_CONTAINS,  '0,        1, 0, 0, 0, 1, '0);
        dir_row(CMD_FREQ,      '0,        1, 0, 0, 0, 1, '0);
        dir_row(CMD_UNUSED_LO, VAL_NEG1,  1, 0, 0, 0, 1, '0);
        dir_row(CMD_ADD,       VAL_MAX,   1, 1, 0, 1, 0, '0);
        dir_row(CMD_ADD,       VAL_MIN,   1, 1, 0, 2, 0, '0);
        dir_row(CMD_ADD,       VAL_NEG1,  0, 0, 0, 0, 0, '0);
        dir_row(CMD_ADD,       '0,        0, 0, 0, 0, 0, '0);
        dir_row(CMD_ADD,       VAL_MAX,   0, 0, 0, 0, 0, '0);
        dir_row(CMD_ADD,       VAL_MAX,   0, 0, 0, 0, 0, '0);
        dir_row(CMD_ADD,       VAL_MIN,   0, 0, 0, 0, 0, '0);
        dir_row(CMD_ADD,       32'd1,     1, 1, 0, 8, 0, '0);
        dir_row(CMD_ADD,       32'd2,     1, 0, 0, 8, 0, '0);
        dir_row(CMD_FREQ,      VAL_MAX,   0, 0, 0, 0, 0, '0);
        dir_row(CMD_SUM,       '0,        0, 0, 0, 0, 0, '0);
        dir_row(CMD_CONTAINS,  32'd2,     0, 0, 0, 0, 0, '0);
        dir_row(CMD_REMOVE,    VAL_MAX,   0, 0, 0, 0, 0, '0);
        dir_row(CMD_REMOVE,    32'h1234_5678, 0, 0, 0, 0, 0, '0);
        dir_row(CMD_UNUSED_HI, VAL_MIN,   0, 0, 0, 0, 0, '0);
        dir_row(CMD_FREQ,      VAL_MAX,   0, 0, 0, 0, 0, '0);
        dir_row(CMD_CLEAR,     '0,        1, 0, 0, 0, 1, '0);
        dir_row(CMD_FREQ,      VAL_MAX,   1, 0, 0, 0, 1, '0);
        dir_row(CMD_SUM,       '0,        1, 0, 0, 0, 1, '0);

        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].value, pick_gap(1'($urandom_range(0, 1))),
                      dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        while (items_sent < dir_rows.size() + RANDOM_ITEMS)
        begin
            for (int i = 0; i < 4; i++)
            begin
                case ($urandom_range(0, 3))
                    0: value_pool[i] = pick_extreme();
                    1: value_pool[i] = $urandom_range(0, 15) - 32'd8;
                    default: value_pool[i] = $urandom;
                endcase
            end
            no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            kind = (r < 70) ? 0 : (r < 85) ? 1 : 2;
            if (kind == 1)
            begin
                v = ($urandom_range(0, 1) == 1) ? pick_extreme() : value_pool[0];
                send_item(CMD_CLEAR, $urandom, pick_gap(no_idle), 0, none);
                repeat (BAG_DEPTH + 1)
                    send_item(CMD_ADD, v, pick_gap(no_idle), 0, none);
                send_item(CMD_SUM, $urandom, pick_gap(no_idle), 0, none);
                send_item(CMD_FREQ, v, pick_gap(no_idle), 0, none);
                send_item(CMD_CONTAINS, v, pick_gap(no_idle), 0, none);
                send_item(CMD_REMOVE, v, pick_gap(no_idle), 0, none);
                send_item(CMD_REMOVE, v, pick_gap(no_idle), 0, none);
                send_item(CMD_SUM, $urandom, pick_gap(no_idle), 0, none);
            end
            else
            begin
                seq_len = $urandom_range(10, 30);
                repeat (seq_len)
                begin
                    if (kind == 2)
                    begin
                        send_item(CMD_W'($urandom_range(0, 7)), $urandom, pick_gap(no_idle),
                                  0, none);
                    end
                    else
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 35)
                            send_item(CMD_ADD, pick_value(), pick_gap(no_idle), 0, none);
                        else if (r < 55)
                            send_item(CMD_REMOVE, pick_value(), pick_gap(no_idle), 0, none);
                        else if (r < 67)
                            send_item(CMD_CONTAINS, pick_value(), pick_gap(no_idle), 0, none);
                        else if (r < 79)
                            send_item(CMD_FREQ, pick_value(), pick_gap(no_idle), 0, none);
                        else if (r < 91)
                            send_item(CMD_SUM, $urandom, pick_gap(no_idle), 0, none);
                        else if (r < 95)
                            send_item(CMD_CLEAR, $urandom, pick_gap(no_idle), 0, none);
                        else
                            send_item($urandom_range(0, 1) ? CMD_UNUSED_LO : CMD_UNUSED_HI,
                                      $urandom, pick_gap(no_idle), 0, none);
                    end
                end
            end
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (BAG_DEPTH + 4) @(posedge clk);
        if (mismatches == 0)
            $display("bounded_bag_table_top: match");
        else
            $display("bounded_bag_table_top: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("bounded_bag_table_top: mismatch");
        $finish;
    end

endmodule

### sim.f
rtl/core/bbt_pkg.sv
rtl/core/bbt_cell.sv
rtl/core/bounded_bag_table_top.sv
verif/bounded_bag_table_top_tb.sv
